// ----- src/amx_pkg.sv -----
// ----------------------------------------------------------------------------
// amx_pkg
// Shared constants, opcodes, status codes and helpers for the accumulator
// machine execute block.
// ----------------------------------------------------------------------------
`default_nettype none

package amx_pkg;

  localparam int DATA_WORDS = 16;
  localparam int DATA_BASE  = 2368;
  localparam int WORD_BITS  = 16;

  localparam int IDX_BITS = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam int CNT_BITS = $clog2(WORD_BITS);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [IDX_BITS-1:0]  idx_t;

  localparam logic [3:0] OP_LOAD  = 4'd1;
  localparam logic [3:0] OP_STORE = 4'd2;
  localparam logic [3:0] OP_IN    = 4'd3;
  localparam logic [3:0] OP_ADD   = 4'd5;
  localparam logic [3:0] OP_SUB   = 4'd6;
  localparam logic [3:0] OP_OUT   = 4'd7;
  localparam logic [3:0] OP_MUL   = 4'd8;
  localparam logic [3:0] OP_DIV   = 4'd9;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_DIVZ  = 2'd2;

  function automatic logic is_mem_op(input logic [3:0] op);
    return (op == OP_LOAD) || (op == OP_STORE) || (op == OP_ADD) ||
           (op == OP_SUB) || (op == OP_MUL) || (op == OP_DIV);
  endfunction

  function automatic logic [15:0] word_to_out(input word_t w);
    logic [63:0] t;
    t = 64'(w);
    return t[15:0];
  endfunction

  function automatic word_t io_to_word(input logic signed [15:0] v);
    logic signed [63:0] t;
    t = 64'(v);
    return t[WORD_BITS-1:0];
  endfunction

  function automatic word_t mag(input word_t w);
    return w[WORD_BITS-1] ? word_t'(-w) : w;
  endfunction

endpackage

`default_nettype wire

// ----- src/amx_div.sv -----
// ----------------------------------------------------------------------------
// amx_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module amx_div (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire amx_pkg::word_t dividend,
  input  wire amx_pkg::word_t divisor,
  output logic                done,
  output amx_pkg::word_t      quotient
);

  amx_pkg::word_t                rem;
  amx_pkg::word_t                dvs;
  logic [amx_pkg::CNT_BITS-1:0]  cnt;
  logic                          busy;
  logic [amx_pkg::WORD_BITS:0]   shifted;
  logic [amx_pkg::WORD_BITS:0]   diff;
  logic                          ge;

  assign shifted = {rem, quotient[amx_pkg::WORD_BITS-1]};
  assign ge      = shifted >= {1'b0, dvs};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= ge ? diff[amx_pkg::WORD_BITS-1:0] : shifted[amx_pkg::WORD_BITS-1:0];
        quotient <= {quotient[amx_pkg::WORD_BITS-2:0], ge};
        cnt      <= cnt + 1'b1;
        if (cnt == amx_pkg::CNT_BITS'(amx_pkg::WORD_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/accumulator_machine_execute.sv -----
// ----------------------------------------------------------------------------
// accumulator_machine_execute
// Executes one accumulator-machine instruction per input word.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries opcode, address and io_data;
// output channel (out_valid/out_ready) carries accumulator, io_write,
// io_device and status, one word per instruction, in order.
// Data memory is a synchronous RAM of DATA_WORDS words with a registered read,
// issued as the instruction is taken; per-word valid bits make it read as
// zero until written.
// From accept to result valid an instruction passes S_EXEC and S_FIN; a multiply
// in the window adds S_MUL, and a divide with a nonzero divisor in the window
// waits in S_DIV for the bit-serial divider. A new instruction is taken only in
// S_IDLE, once the last one has finished; one instruction is in flight at a time.
// The output register decouples the sides: a new instruction is taken while
// a result waits; a stalled receiver holds the result and, once the next
// instruction finishes, stalls the input.
// Reset clears the accumulator, the memory valid bits and both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module accumulator_machine_execute (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [3:0]         opcode,
  input  wire logic [11:0]        address,
  input  wire logic signed [15:0] io_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      accumulator,
  output logic                    io_write,
  output logic [11:0]             io_device,
  output logic [1:0]              status
);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_MUL, S_DIV, S_FIN} state_t;

  state_t                state;
  amx_pkg::word_t        acc;
  amx_pkg::word_t        prod;
  logic [3:0]            op_q;
  logic [11:0]           addr_q;
  logic signed [15:0]    io_q;
  amx_pkg::idx_t         idx_q;
  logic                  in_win_q;
  logic                  div_neg;
  logic                  res_wr;
  logic [11:0]           res_dev;
  logic [1:0]            res_st;

  amx_pkg::word_t        mem [amx_pkg::DATA_WORDS];
  logic [amx_pkg::DATA_WORDS-1:0] vld;
  amx_pkg::word_t        rd_word;
  logic                  rd_vld;
  amx_pkg::word_t        mword;

  logic [12:0]           off;
  logic                  in_win;
  logic                  take;
  logic                  mem_we;
  logic                  div_start;
  logic                  div_done;
  amx_pkg::word_t        div_q;

  assign in_ready = (state == S_IDLE);
  assign take     = in_valid && in_ready;
  assign off      = {1'b0, address} - 13'(amx_pkg::DATA_BASE);
  assign in_win   = !off[12] && (off < 13'(amx_pkg::DATA_WORDS));
  assign mword    = rd_vld ? rd_word : '0;
  assign mem_we   = (state == S_EXEC) && (op_q == amx_pkg::OP_STORE) && in_win_q;
  assign div_start = (state == S_EXEC) && (op_q == amx_pkg::OP_DIV) && in_win_q &&
                     (mword != '0);

  // data memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx_q] <= acc;
    end
    if (take && in_win) begin
      rd_word <= mem[off[amx_pkg::IDX_BITS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (mem_we) begin
        vld[idx_q] <= 1'b1;
      end
      if (take) begin
        rd_vld <= in_win && vld[off[amx_pkg::IDX_BITS-1:0]];
      end
    end
  end

  amx_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (amx_pkg::mag(acc)),
    .divisor  (amx_pkg::mag(mword)),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take) begin
            op_q     <= opcode;
            addr_q   <= address;
            io_q     <= io_data;
            idx_q    <= off[amx_pkg::IDX_BITS-1:0];
            in_win_q <= in_win;
            state    <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_wr  <= (op_q == amx_pkg::OP_OUT);
          res_dev <= (op_q == amx_pkg::OP_OUT) ? addr_q : '0;
          priority if (amx_pkg::is_mem_op(op_q) && !in_win_q) begin
            res_st <= amx_pkg::ST_RANGE;
          end else if ((op_q == amx_pkg::OP_DIV) && (mword == '0)) begin
            res_st <= amx_pkg::ST_DIVZ;
          end else begin
            res_st <= amx_pkg::ST_OK;
          end
          priority if (div_start) begin
            state <= S_DIV;
          end else if ((op_q == amx_pkg::OP_MUL) && in_win_q) begin
            state <= S_MUL;
          end else begin
            state <= S_FIN;
          end
          if (amx_pkg::is_mem_op(op_q) && in_win_q) begin
            priority case (op_q)
              amx_pkg::OP_LOAD: acc <= mword;
              amx_pkg::OP_ADD:  acc <= acc + mword;
              amx_pkg::OP_SUB:  acc <= acc - mword;
              amx_pkg::OP_MUL:  prod <= acc * mword;
              amx_pkg::OP_DIV: begin
                div_neg <= acc[amx_pkg::WORD_BITS-1] ^ mword[amx_pkg::WORD_BITS-1];
              end
              default: ;
            endcase
          end else if (op_q == amx_pkg::OP_IN) begin
            acc <= amx_pkg::io_to_word(io_q);
          end
        end
        S_MUL: begin
          acc   <= prod;
          state <= S_FIN;
        end
        S_DIV: begin
          if (div_done) begin
            acc   <= div_neg ? amx_pkg::word_t'(-div_q) : div_q;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            accumulator <= amx_pkg::word_to_out(acc);
            io_write    <= res_wr;
            io_device   <= res_dev;
            status      <= res_st;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside divide state");

  a_take_to_exec: assert property (@(posedge clk) disable iff (rst)
    take |=> state == S_EXEC)
    else $error("accepted word did not move to execute");

  a_write_in_window: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> in_win_q)
    else $error("memory write outside data window");

  a_io_write_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && io_write |-> status == amx_pkg::ST_OK)
    else $error("device write reported with error status");

  a_fin_loads_output: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && (!out_valid || out_ready) |=> out_valid && state == S_IDLE)
    else $error("finished result not loaded into output register");

endmodule

`default_nettype wire
